[rtl/npcs_pkg.sv]
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared widths, constants and controller/datapath interface types for the
// nearest palette color search block.
// ----------------------------------------------------------------------------
package npcs_pkg;

	localparam int unsigned PALETTE_ENTRIES_DEF = 4096;
	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned IDX_W   = 12;
	localparam int unsigned SIZE_W  = 13;
	localparam int unsigned SQ_W    = 2 * CHAN_W;
	localparam int unsigned DIST_W  = SQ_W + 2;
	localparam int unsigned ENTRY_W = 4 * CHAN_W + 1;

	// larger than any reachable distance
	localparam logic [DIST_W-1:0] DIST_START = DIST_W'(255 * 255 * 4 + 1);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic wr;          // store the incoming entry
		logic start;       // latch query color, reset best, point at entry 1
		logic transparent; // query color is all zero
		logic issue;       // read one entry and advance the scan address
		logic load_out;    // move the result into the output register
	} dp_cmd_t;

	typedef struct packed {
		logic query_zero;  // incoming color is all zero
		logic empty;       // nothing to scan
		logic last;        // scan address is the final entry
		logic busy;        // compare pipeline holds an entry
		logic out_full;    // output register holds an untaken result
		logic out_taken;   // output result is taken this cycle
	} dp_status_t;

endpackage

[rtl/npcs_ctrl.sv]
// ----------------------------------------------------------------------------
// npcs_ctrl
// Controller: accepts requests, sequences the palette scan, drains the
// compare pipeline and hands the result to the output register.
// ----------------------------------------------------------------------------
module npcs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 op,
	output logic                 in_stall,
	input  npcs_pkg::dp_status_t status,
	output npcs_pkg::dp_cmd_t    cmd
);
	import npcs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	always_comb begin
		cmd             = '0;
		cmd.wr          = accept && (op == OP_WRITE);
		cmd.start       = accept && (op == OP_QUERY);
		cmd.transparent = status.query_zero;
		cmd.issue       = (state_q == ST_SCAN);
		cmd.load_out    = (state_q == ST_OUT) && (!status.out_full || status.out_taken);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (op == OP_QUERY)) begin
						if (status.query_zero || status.empty)
							state_q <= ST_DRAIN;
						else
							state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (status.last)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!status.busy)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (cmd.load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/npcs_dpath.sv]
// ----------------------------------------------------------------------------
// npcs_dpath
// Datapath: palette memory, size register, scan address, distance pipeline,
// best-match tracking and the output register.
// ----------------------------------------------------------------------------
module npcs_dpath #(
	parameter int unsigned PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  npcs_pkg::dp_cmd_t           cmd,
	output npcs_pkg::dp_status_t        status,
	input  logic [npcs_pkg::IDX_W-1:0]  entry_index,
	input  logic [npcs_pkg::CHAN_W-1:0] red,
	input  logic [npcs_pkg::CHAN_W-1:0] green,
	input  logic [npcs_pkg::CHAN_W-1:0] blue,
	input  logic [npcs_pkg::CHAN_W-1:0] matte,
	input  logic                        solid,
	input  logic                        size_we,
	input  logic [npcs_pkg::SIZE_W-1:0] size_data,
	input  logic                        out_stall,
	output logic                        out_valid,
	output logic [npcs_pkg::IDX_W-1:0]  best_index,
	output logic                        found
);
	import npcs_pkg::*;

	localparam int unsigned AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(PALETTE_ENTRIES);

	logic [ENTRY_W-1:0] mem_q [PALETTE_ENTRIES];

	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] limit;
	logic [AW-1:0]     addr_q;
	logic [CHAN_W-1:0] qcol_q [4];

	logic [ENTRY_W-1:0] rdata_s1;
	logic               valid_s1;
	logic [AW-1:0]      idx_s1;

	logic [SQ_W-1:0]    sq_s2 [4];
	logic               solid_s2;
	logic               valid_s2;
	logic [AW-1:0]      idx_s2;

	logic [CHAN_W-1:0]  ecol [4];
	logic [SQ_W-1:0]    sq   [4];
	logic [DIST_W-1:0]  dist_sum;

	logic [DIST_W-1:0]  best_dist_q;
	logic [AW-1:0]      best_q;
	logic               found_q;

	logic               out_valid_q;
	logic [IDX_W-1:0]   best_index_q;
	logic               found_out_q;

	assign limit = (size_q > SIZE_MAX) ? SIZE_MAX : size_q;

	always_comb begin
		status            = '0;
		status.query_zero = (red == '0) && (green == '0) && (blue == '0) && (matte == '0);
		status.empty      = (limit <= SIZE_W'(1));
		status.last       = (SIZE_W'(addr_q) == (limit - SIZE_W'(1)));
		status.busy       = valid_s1 || valid_s2;
		status.out_full   = out_valid_q;
		status.out_taken  = out_valid_q && !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			size_q <= '0;
		else if (size_we)
			size_q <= size_data;
	end

	// palette memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr && ({1'b0, entry_index} < SIZE_MAX))
			mem_q[entry_index[AW-1:0]] <= {red, green, blue, matte, solid};
		rdata_s1 <= mem_q[addr_q];
		idx_s1   <= addr_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qcol_q[0] <= red;
			qcol_q[1] <= green;
			qcol_q[2] <= blue;
			qcol_q[3] <= matte;
			addr_q    <= AW'(1);
		end else if (cmd.issue) begin
			addr_q <= addr_q + AW'(1);
		end
	end

	assign ecol[0] = rdata_s1[ENTRY_W-1 -: CHAN_W];
	assign ecol[1] = rdata_s1[ENTRY_W-1-CHAN_W -: CHAN_W];
	assign ecol[2] = rdata_s1[ENTRY_W-1-2*CHAN_W -: CHAN_W];
	assign ecol[3] = rdata_s1[ENTRY_W-1-3*CHAN_W -: CHAN_W];

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			logic [CHAN_W-1:0] d;
			d     = (ecol[c] > qcol_q[c]) ? (ecol[c] - qcol_q[c]) : (qcol_q[c] - ecol[c]);
			sq[c] = SQ_W'(d) * SQ_W'(d);
		end
	end

	assign dist_sum = DIST_W'(sq_s2[0]) + DIST_W'(sq_s2[1]) + DIST_W'(sq_s2[2])
		+ DIST_W'(sq_s2[3]);

	always_ff @(posedge clk) begin
		sq_s2    <= sq;
		solid_s2 <= rdata_s1[0];
		idx_s2   <= idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
		end
	end

	// strict less-than keeps the lowest index on ties
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_dist_q <= DIST_START;
			best_q      <= '0;
			found_q     <= cmd.transparent;
		end else if (valid_s2 && solid_s2 && (dist_sum < best_dist_q)) begin
			best_dist_q <= dist_sum;
			best_q      <= idx_s2;
			found_q     <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			best_index_q <= IDX_W'(best_q);
			found_out_q  <= found_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign best_index = best_index_q;
	assign found      = found_out_q;

endmodule

[rtl/nearest_palette_color_search_top.sv]
// ----------------------------------------------------------------------------
// nearest_palette_color_search_top
// Palette store with nearest solid color lookup over RGBA squared distance.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): op 0 stores one palette entry at
// entry_index and gives no result; op 1 queries the color and gives one
// result (best_index, found) on the output channel.
// A query scans entries 1 to L-1, L = min(palette_size, PALETTE_ENTRIES), one
// entry per cycle through the single read port of the palette memory, then
// drains a two-stage distance pipeline before the result reaches out_valid.
// An all-zero query color or L of 0 or 1 skips the scan.
// Only one request is in flight: in_stall stays high from a query's accept
// until its result is loaded into the output register.
// The result waits in the output register while out_stall is high; a write
// request is still accepted meanwhile, a later query finishes its scan and
// holds until the register frees.
// palette_size is written through cfg_valid / cfg_ready (always ready).
// Reset clears palette_size to 0 and the control state; palette contents are
// undefined until written, and no clearing pass runs.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_top #(
	parameter int unsigned PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        op,
	input  logic [npcs_pkg::IDX_W-1:0]  entry_index,
	input  logic [npcs_pkg::CHAN_W-1:0] red,
	input  logic [npcs_pkg::CHAN_W-1:0] green,
	input  logic [npcs_pkg::CHAN_W-1:0] blue,
	input  logic [npcs_pkg::CHAN_W-1:0] matte,
	input  logic                        solid,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [npcs_pkg::IDX_W-1:0]  best_index,
	output logic                        found,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [npcs_pkg::SIZE_W-1:0] palette_size
);
	import npcs_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	npcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	npcs_dpath #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.entry_index (entry_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.matte       (matte),
		.solid       (solid),
		.size_we     (cfg_valid && cfg_ready),
		.size_data   (palette_size),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.best_index  (best_index),
		.found       (found)
	);

endmodule
